/* rtl/dss_pkg.sv */
// Shared types and codes for the dual shared stack.
`default_nettype none
package dss_pkg;

    // Commands carried by an input request
    typedef enum logic [1:0] {
        CMD_PUSH  = 2'd0,
        CMD_POP   = 2'd1,
        CMD_PEEK  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    // Status returned with every result
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } t_state;

    // Result load order from the sequencer to the output register
    typedef struct packed {
        logic    load;       // load the output register this cycle
        logic    from_mem;   // take the value from the store read port
        logic    empty_val;  // value is all ones at the data width
        t_status status;
    } t_result;

endpackage
`default_nettype wire

/* rtl/dss_store.sv */
// Element store: one write port, one read port with registered read data.
`default_nettype none
module dss_store #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32,
    parameter int AW         = 6
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_we,
    input  wire logic [AW-1:0]         i_waddr,
    input  wire logic [DATA_WIDTH-1:0] i_wdata,
    input  wire logic                  i_re,
    input  wire logic [AW-1:0]         i_raddr,
    output logic      [DATA_WIDTH-1:0] o_rdata
);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rdata;

    // Write one entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read one entry, hold the data until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

/* rtl/dss_ctrl.sv */
// Stack pointers and request sequencer for the dual shared stack.
`default_nettype none
module dss_ctrl #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32,
    parameter int AW         = 6,
    parameter int CW         = 7
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    input  wire logic [1:0]            i_command,
    input  wire logic                  i_stack_select,
    input  wire logic [DATA_WIDTH-1:0] i_wdata,
    input  wire logic                  i_out_free,
    output logic                       o_stall,
    output logic                       o_we,
    output logic      [AW-1:0]         o_waddr,
    output logic      [DATA_WIDTH-1:0] o_wdata,
    output logic                       o_re,
    output logic      [AW-1:0]         o_raddr,
    output dss_pkg::t_result           o_result
);

    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    dss_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_lower, n_lower;
    logic [CW-1:0]   r_upper, n_upper;

    dss_pkg::t_cmd   w_cmd;
    logic            w_accept;
    logic            w_full;
    logic            w_empty;
    logic [CW-1:0]   w_lower_dec;
    logic [CW-1:0]   w_upper_dec;

    assign w_cmd       = dss_pkg::t_cmd'(i_command);
    assign o_stall     = (r_state != dss_pkg::S_IDLE) || !i_out_free;
    assign w_accept    = i_valid && !o_stall;
    assign w_full      = (r_lower == r_upper);
    assign w_empty     = i_stack_select ? (r_upper == DEPTH_C) : (r_lower == '0);
    assign w_lower_dec = r_lower - CW'(1);
    assign w_upper_dec = r_upper - CW'(1);
    assign o_wdata     = i_wdata;

    // Decode the request, drive the store and move the pointers
    always_comb begin
        n_state  = r_state;
        n_lower  = r_lower;
        n_upper  = r_upper;
        o_we     = 1'b0;
        o_waddr  = r_lower[AW-1:0];
        o_re     = 1'b0;
        o_raddr  = w_lower_dec[AW-1:0];
        o_result = '{load: 1'b0, from_mem: 1'b0, empty_val: 1'b0,
                     status: dss_pkg::ST_OK};
        case (r_state)
            dss_pkg::S_IDLE: begin
                if (w_accept) begin
                    case (w_cmd)
                        dss_pkg::CMD_PUSH: begin
                            o_result.load = 1'b1;
                            if (w_full) begin
                                o_result.status = dss_pkg::ST_FULL;
                            end else if (!i_stack_select) begin
                                o_we    = 1'b1;
                                o_waddr = r_lower[AW-1:0];
                                n_lower = r_lower + CW'(1);
                            end else begin
                                o_we    = 1'b1;
                                o_waddr = w_upper_dec[AW-1:0];
                                n_upper = w_upper_dec;
                            end
                        end
                        dss_pkg::CMD_POP, dss_pkg::CMD_PEEK: begin
                            if (w_empty) begin
                                o_result.load      = 1'b1;
                                o_result.empty_val = 1'b1;
                                o_result.status    = dss_pkg::ST_EMPTY;
                            end else begin
                                o_re    = 1'b1;
                                n_state = dss_pkg::S_READ;
                                if (!i_stack_select) begin
                                    o_raddr = w_lower_dec[AW-1:0];
                                    if (w_cmd == dss_pkg::CMD_POP) begin
                                        n_lower = w_lower_dec;
                                    end
                                end else begin
                                    o_raddr = r_upper[AW-1:0];
                                    if (w_cmd == dss_pkg::CMD_POP) begin
                                        n_upper = r_upper + CW'(1);
                                    end
                                end
                            end
                        end
                        default: begin
                            o_result.load = 1'b1;
                        end
                    endcase
                end
            end
            dss_pkg::S_READ: begin
                // Hand the read data over once the output register frees up
                if (i_out_free) begin
                    o_result.load     = 1'b1;
                    o_result.from_mem = 1'b1;
                    n_state           = dss_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dss_pkg::S_IDLE;
            end
        endcase
    end

    // Advance state and pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dss_pkg::S_IDLE;
            r_lower <= '0;
            r_upper <= DEPTH_C;
        end else begin
            r_state <= n_state;
            r_lower <= n_lower;
            r_upper <= n_upper;
        end
    end

endmodule
`default_nettype wire

/* rtl/dual_shared_stack.sv */
// Top level of the dual shared stack: sequencer, element store, output register.
//
// Two stacks share one store of DEPTH words. Stack 0 grows up from entry 0,
// stack 1 grows down from entry DEPTH-1.
// Input channel: i_valid / o_stall carry one request (i_command, i_stack_select,
// i_push_value); a request is taken at an edge with i_valid high, o_stall low.
// Output channel: o_valid / i_stall carry one result (o_read_value, o_status)
// for every request, in request order.
// A push, a refused request or an unused command is loaded into the output
// register at the edge that takes it. A pop or peek on a non-empty stack
// reads the store into its read data register, then waits in the read state
// until the output register is free. Pushes are taken one per cycle while the
// receiver does not stall; one request is in flight at a time.
// Reset (i_rst_n low at a clock edge) empties both stacks and the output
// register; store contents are left as they are.
// While the receiver stalls, the result waits in the output register and
// o_stall stays high until it can be replaced.
`default_nettype none
module dual_shared_stack #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [1:0]         i_command,
    input  wire logic               i_stack_select,
    input  wire logic signed [31:0] i_push_value,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [31:0]      o_read_value,
    output logic [1:0]              o_status
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic                  w_out_free;
    logic                  w_we;
    logic                  w_re;
    logic [AW-1:0]         w_waddr;
    logic [AW-1:0]         w_raddr;
    logic [DATA_WIDTH-1:0] w_push_data;
    logic [DATA_WIDTH-1:0] w_wdata;
    logic [DATA_WIDTH-1:0] w_rdata;
    logic [63:0]           w_push_ext;
    logic [63:0]           w_rdata_ext;
    logic [63:0]           w_ones_ext;
    dss_pkg::t_result      w_result;

    logic                  r_out_valid;
    logic [31:0]           r_read_value;
    dss_pkg::t_status      r_status;

    // Fit the push value to the data width
    assign w_push_ext  = 64'($unsigned(i_push_value));
    assign w_push_data = w_push_ext[DATA_WIDTH-1:0];

    // Fit read data and the empty marker to the 32-bit result field
    assign w_rdata_ext = 64'(w_rdata);
    assign w_ones_ext  = 64'({DATA_WIDTH{1'b1}});

    assign w_out_free = !r_out_valid || !i_stall;

    dss_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .AW         (AW),
        .CW         (CW)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_command      (i_command),
        .i_stack_select (i_stack_select),
        .i_wdata        (w_push_data),
        .i_out_free     (w_out_free),
        .o_stall        (o_stall),
        .o_we           (w_we),
        .o_waddr        (w_waddr),
        .o_wdata        (w_wdata),
        .o_re           (w_re),
        .o_raddr        (w_raddr),
        .o_result       (w_result)
    );

    dss_store #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .AW         (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Output valid: set on load, drop once the receiver takes the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_result.load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload: hold while stalled
    always_ff @(posedge i_clk) begin
        if (w_result.load) begin
            r_status <= w_result.status;
            if (w_result.from_mem) begin
                r_read_value <= w_rdata_ext[31:0];
            end else if (w_result.empty_val) begin
                r_read_value <= w_ones_ext[31:0];
            end else begin
                r_read_value <= '0;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_read_value = $signed(r_read_value);
    assign o_status     = r_status;

endmodule
`default_nettype wire
